### rtl/core/shatc_pkg.sv
// Package for the SHA-256 share target check: shared types, constants and the
// round constant table. No dependencies.
package shatc_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned ROUNDS      = 64;
   localparam int unsigned ROUND_W     = $clog2(ROUNDS);
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned TARGET_REGS = 4;

   typedef logic [WORD_W-1:0] word_type;
   // element 0 is working variable a (or H0)
   typedef word_type [7:0]    hash_type;
   // element 0 is message word 0
   typedef word_type [15:0]   block_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_W0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_W1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_W2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_W3 = 3'd3;

   localparam logic [CSR_DATA_W-1:0] TARGET_RESET = '1;

   // 72-byte message: pad bit right after it, length in bits in the last word
   localparam word_type MSG_PAD_WORD = 32'h8000_0000;
   localparam word_type MSG_BITS     = 32'd576;

   typedef struct packed {
      logic [63:0] state_w0;
      logic [63:0] state_w1;
      logic [63:0] state_w2;
      logic [63:0] state_w3;
      logic [63:0] share_nonce;
      logic [63:0] key_w0;
      logic [63:0] key_w1;
      logic [63:0] key_w2;
      logic [63:0] key_w3;
   } req_type;

   typedef struct packed {
      logic        is_winner;
      logic [63:0] digest_w0;
      logic [63:0] digest_w1;
      logic [63:0] digest_w2;
      logic [63:0] digest_w3;
   } rsp_type;

   // command and status between sequencer and compression unit
   typedef struct packed {
      logic      load;
      hash_type  chain;
      block_type blk;
   } cmp_cmd_type;

   typedef struct packed {
      logic     done;
      hash_type vars;
   } cmp_status_type;

   localparam hash_type INIT_H = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic word_type round_k(input logic [ROUND_W-1:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

### rtl/core/shatc_compress.sv
// SHA-256 compression unit: one round per cycle over a 16-word schedule window.
// Depends on shatc_pkg.
module shatc_compress (
   input  logic                     clock,
   input  logic                     reset,
   input  shatc_pkg::cmp_cmd_type   cmd,
   output shatc_pkg::cmp_status_type status
);

   shatc_pkg::hash_type               vars_ff, vars_in;
   shatc_pkg::block_type              sched_ff, sched_in;
   logic [shatc_pkg::ROUND_W-1:0]     round_ff, round_in;
   logic                              run_ff, run_in;
   logic                              done_ff, done_in;

   function automatic shatc_pkg::word_type rotr(input shatc_pkg::word_type x,
                                                input int unsigned n);
      return (x >> n) | (x << (shatc_pkg::WORD_W - n));
   endfunction

   shatc_pkg::word_type w_new, t1, t2, big_s0, big_s1, ch, maj, sm0, sm1;

   always_comb begin
      // next schedule word from the window, w[t+16]
      sm0 = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      sm1 = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      w_new = sched_ff[0] + sm0 + sched_ff[9] + sm1;

      big_s1 = rotr(vars_ff[4], 6) ^ rotr(vars_ff[4], 11) ^ rotr(vars_ff[4], 25);
      ch     = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      big_s0 = rotr(vars_ff[0], 2) ^ rotr(vars_ff[0], 13) ^ rotr(vars_ff[0], 22);
      maj    = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
             ^ (vars_ff[1] & vars_ff[2]);
      t1 = vars_ff[7] + big_s1 + ch + shatc_pkg::round_k(round_ff) + sched_ff[0];
      t2 = big_s0 + maj;

      vars_in  = vars_ff;
      sched_in = sched_ff;
      round_in = round_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (cmd.load) begin
         vars_in  = cmd.chain;
         sched_in = cmd.blk;
         round_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[15] = w_new;
         round_in = round_ff + 1'b1;
         if (round_ff == shatc_pkg::ROUND_W'(shatc_pkg::ROUNDS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      vars_ff  <= vars_in;
      sched_ff <= sched_in;
   end

   assign status.done = done_ff;
   assign status.vars = vars_ff;

endmodule

### rtl/core/sha256_share_target_check.sv
// Top level of the SHA-256 share target check: message build, chaining,
// target registers and the compare. Depends on shatc_pkg and shatc_compress.

// One share is taken when start is high and busy low; busy then stays high
// until the result goes out, so a share is taken only after the last is done:
// the 72-byte message pads to two SHA-256 blocks, and one shared round unit
// runs each block's 64 rounds at one round a cycle, followed by the chaining
// add, the 256-bit compare against the target and the output register. The
// result on rsp_item is marked by rsp_strobe, high for exactly one cycle; the
// receiver cannot stall it, so it must take it then. Target registers reset
// to all ones and are written through csr_we; the user must write them only
// while the block is idle, not enforced here; writes above index 3 are dropped.
module sha256_share_target_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  shatc_pkg::req_type                   req_item,
   output logic                                 rsp_strobe,
   output shatc_pkg::rsp_type                   rsp_item,
   input  logic                                 csr_we,
   input  logic [shatc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [shatc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_BLK0 = 5'b00010,
      ST_MID  = 5'b00100,
      ST_BLK1 = 5'b01000,
      ST_CMP  = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   shatc_pkg::hash_type               h_ff, h_in;
   logic [63:0]                       key3_ff, key3_in;
   logic [shatc_pkg::CSR_DATA_W-1:0]  target_ff [shatc_pkg::TARGET_REGS];
   logic                              strobe_ff, strobe_in;
   shatc_pkg::rsp_type                rsp_ff, rsp_in;

   shatc_pkg::cmp_cmd_type            cmd;
   shatc_pkg::cmp_status_type         status;
   shatc_pkg::block_type              blk0, blk1;
   shatc_pkg::hash_type               h_sum;
   logic [255:0]                      digest, target;
   logic                              accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // block 0: state hash, nonce byte-reversed, first three key words
   always_comb begin
      blk0[0]  = req_item.state_w0[63:32];
      blk0[1]  = req_item.state_w0[31:0];
      blk0[2]  = req_item.state_w1[63:32];
      blk0[3]  = req_item.state_w1[31:0];
      blk0[4]  = req_item.state_w2[63:32];
      blk0[5]  = req_item.state_w2[31:0];
      blk0[6]  = req_item.state_w3[63:32];
      blk0[7]  = req_item.state_w3[31:0];
      blk0[8]  = {req_item.share_nonce[7:0],   req_item.share_nonce[15:8],
                  req_item.share_nonce[23:16], req_item.share_nonce[31:24]};
      blk0[9]  = {req_item.share_nonce[39:32], req_item.share_nonce[47:40],
                  req_item.share_nonce[55:48], req_item.share_nonce[63:56]};
      blk0[10] = req_item.key_w0[63:32];
      blk0[11] = req_item.key_w0[31:0];
      blk0[12] = req_item.key_w1[63:32];
      blk0[13] = req_item.key_w1[31:0];
      blk0[14] = req_item.key_w2[63:32];
      blk0[15] = req_item.key_w2[31:0];

      blk1     = '0;
      blk1[0]  = key3_ff[63:32];
      blk1[1]  = key3_ff[31:0];
      blk1[2]  = shatc_pkg::MSG_PAD_WORD;
      blk1[15] = shatc_pkg::MSG_BITS;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         h_sum[i] = h_ff[i] + status.vars[i];
      end
   end

   assign digest = {h_ff[0], h_ff[1], h_ff[2], h_ff[3],
                    h_ff[4], h_ff[5], h_ff[6], h_ff[7]};
   assign target = {target_ff[0], target_ff[1], target_ff[2], target_ff[3]};

   always_comb begin
      state_in  = state_ff;
      h_in      = h_ff;
      key3_in   = key3_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      cmd.load  = 1'b0;
      cmd.chain = shatc_pkg::INIT_H;
      cmd.blk   = blk0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               h_in     = shatc_pkg::INIT_H;
               key3_in  = req_item.key_w3;
               state_in = ST_BLK0;
            end
         end
         ST_BLK0: begin
            if (status.done) begin
               h_in     = h_sum;
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            cmd.load  = 1'b1;
            cmd.chain = h_ff;
            cmd.blk   = blk1;
            state_in  = ST_BLK1;
         end
         ST_BLK1: begin
            if (status.done) begin
               h_in     = h_sum;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            rsp_in.is_winner = (digest <= target);
            rsp_in.digest_w0 = digest[255:192];
            rsp_in.digest_w1 = digest[191:128];
            rsp_in.digest_w2 = digest[127:64];
            rsp_in.digest_w3 = digest[63:0];
            strobe_in        = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      h_ff    <= h_in;
      key3_ff <= key3_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < shatc_pkg::TARGET_REGS; i++) begin
            target_ff[i] <= shatc_pkg::TARGET_RESET;
         end
      end else if (csr_we) begin
         case (csr_index)
            shatc_pkg::CSR_TARGET_W0: target_ff[0] <= csr_wdata;
            shatc_pkg::CSR_TARGET_W1: target_ff[1] <= csr_wdata;
            shatc_pkg::CSR_TARGET_W2: target_ff[2] <= csr_wdata;
            shatc_pkg::CSR_TARGET_W3: target_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   shatc_compress u_compress (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
